>>> hdl/msp_pkg.sv
// shared types and constants for the min path sum block
// no dependencies
package msp_pkg;

	localparam int MAX_ROWS = 64;
	localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RCNT_W   = 7;
	localparam int EFF_W    = (RCNT_W > ROW_W + 1) ? RCNT_W : ROW_W + 1;
	localparam int CELL_W   = 16;
	localparam int COST_W   = 32;
	localparam int SUM_W    = COST_W + 2;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	// register index taken from paddr above the byte offset
	localparam logic REG_ROW_COUNT = 1'b0;

	typedef logic signed [CELL_W-1:0] cell_t;
	typedef logic signed [COST_W-1:0] cost_t;

	// broadcast control for the row of cells
	typedef struct packed {
		logic             wr;
		logic [ROW_W-1:0] row;
		cost_t            cost;
		logic             col_end;
		logic             load;
		logic             shift;
	} msp_ctl_t;

endpackage

>>> hdl/msp_ifs.sv
// stream interfaces for the min path sum block: cell input and result output
// depends on msp_pkg
interface msp_in_if;
	logic                  valid;
	logic                  ready;
	msp_pkg::cell_t        cell_value;
	logic                  matrix_end;

	modport source (output valid, output cell_value, output matrix_end, input ready);
	modport sink (input valid, input cell_value, input matrix_end, output ready);
endinterface

interface msp_out_if;
	logic                  valid;
	logic                  ready;
	msp_pkg::cost_t        path_min;
	logic                  saturated;

	modport source (output valid, output path_min, output saturated, input ready);
	modport sink (input valid, input path_min, input saturated, output ready);
endinterface

>>> hdl/min_path_sum_column_dp.sv
// top level of the min path sum block: config port, head arithmetic, cell row
// depends on msp_pkg, msp_ifs and msp_cell
//
// Usage:
// Grid cells arrive on cell_in, one beat per cell, column-major: rows 0 to
// row_count-1 of a column, then the next column. Each cell gets its own cost
// plus the cheapest of the up to three neighbors in the previous column,
// saturated to 32 bits. The beat flagged matrix_end produces one result beat
// on path_out with the minimum cost of its column and the sticky saturation
// flag of the matrix; after it the block starts over on a new matrix.
// The result beat is registered and valid in the cycle after the matrix_end beat.
// Throughput: one cell per cycle while no realign runs and no held result stalls;
// each cell is one add and three compares in the head stage, the previous
// column sits in a row of cells whose window taps shift by one row per beat,
// so the three neighbors are always at the head. A new cell is taken in the
// cycle the held result drains. row_count sits at byte address 0 of the APB
// port (reset 1, 0 acts as 1). A write to it realigns the window with cell_in
// not ready: a load state, a shift state that steps the window once per row
// already taken in the open column, then back to run. Reset clears control
// state and sets row_count to 1; the stored costs are undefined until written.
// When path_out stalls with a result held, cell_in waits.
module min_path_sum_column_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [msp_pkg::PADDR_W-1:0] paddr,
	input  logic [msp_pkg::PDATA_W-1:0] pwdata,
	output logic [msp_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	msp_in_if.sink                      cell_in,
	msp_out_if.source                   path_out
);
	import msp_pkg::*;

	localparam logic [1:0] SEQ_RUN   = 2'd0;
	localparam logic [1:0] SEQ_LOAD  = 2'd1;
	localparam logic [1:0] SEQ_SHIFT = 2'd2;
	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sd2147483647);
	localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(64'sd2147483648);

	// config register
	logic [RCNT_W-1:0] row_count_q;
	logic              cfg_wr;

	// control state
	logic [ROW_W-1:0]  row_pos_q;
	logic              first_col_q;
	cost_t             run_min_q;
	logic              sat_seen_q;
	logic [1:0]        seq_q;
	logic [ROW_W-1:0]  cnt_q;
	cost_t             w0_q;

	// output register
	logic              out_valid_q;
	cost_t             out_min_q;
	logic              out_sat_q;

	// head datapath
	logic [EFF_W-1:0]  rows_eff;
	logic [EFF_W-1:0]  row_pos_x;
	logic [ROW_W-1:0]  row;
	logic [EFF_W-1:0]  row_nxt;
	logic              col_done;
	logic              acc;
	logic              is_end;
	cost_t             best;
	logic signed [SUM_W-1:0] sum_w;
	logic              ovf;
	cost_t             sat_cost;
	cost_t             cost;
	logic              sat_d;
	cost_t             run_min_d;
	logic              realign_go;

	msp_ctl_t          ctl;
	cost_t             win_w [0:MAX_ROWS+1];

	// apb: pready tied high, write lands at the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ROW_COUNT);
	assign prdata = (paddr[2] == REG_ROW_COUNT) ? PDATA_W'(row_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= RCNT_W'(1);
		end else if (cfg_wr) begin
			row_count_q <= pwdata[RCNT_W-1:0];
		end
	end

	// effective rows: zero acts as one, clamp to the cell count
	always_comb begin
		if (row_count_q == '0) begin
			rows_eff = EFF_W'(1);
		end else if (EFF_W'(row_count_q) > EFF_W'(MAX_ROWS)) begin
			rows_eff = EFF_W'(MAX_ROWS);
		end else begin
			rows_eff = EFF_W'(row_count_q);
		end
	end

	// clamp row position if row_count shrank inside a column
	always_comb begin
		row_pos_x = EFF_W'(row_pos_q);
		if (row_pos_x >= rows_eff) begin
			row = ROW_W'(rows_eff - EFF_W'(1));
		end else begin
			row = row_pos_q;
		end
		row_nxt  = EFF_W'(row) + EFF_W'(1);
		col_done = (row_nxt >= rows_eff);
	end

	assign cell_in.ready = (seq_q == SEQ_RUN) && (!out_valid_q || path_out.ready);
	assign acc           = cell_in.valid && cell_in.ready;
	assign is_end        = cell_in.matrix_end;

	// window head: w0 = prev[row-1], w1 = prev[row], w2 = prev[row+1]
	always_comb begin
		best = win_w[1];
		if ((row != '0) && (win_w[0] < best)) begin
			best = win_w[0];
		end
		if ((row_nxt < rows_eff) && (win_w[2] < best)) begin
			best = win_w[2];
		end
	end

	// saturating add
	always_comb begin
		sum_w = SUM_W'(cell_in.cell_value) + SUM_W'(best);
		ovf   = 1'b0;
		if (sum_w > SUM_MAX) begin
			sat_cost = cost_t'(SUM_MAX);
			ovf      = 1'b1;
		end else if (sum_w < SUM_MIN) begin
			sat_cost = cost_t'(SUM_MIN);
			ovf      = 1'b1;
		end else begin
			sat_cost = cost_t'(sum_w);
		end
		cost  = first_col_q ? cost_t'(cell_in.cell_value) : sat_cost;
		sat_d = sat_seen_q || (!first_col_q && ovf);
		run_min_d = ((row == '0) || (cost < run_min_q)) ? cost : run_min_q;
	end

	// realign sequencer target is reached once cnt equals the clamped row
	assign realign_go = (seq_q == SEQ_SHIFT) && (cnt_q != row);

	always_comb begin
		ctl.wr      = acc;
		ctl.row     = row;
		ctl.cost    = cost;
		ctl.col_end = acc && col_done;
		ctl.load    = (acc && (col_done || is_end)) || (seq_q == SEQ_LOAD);
		ctl.shift   = (acc && !col_done && !is_end) || realign_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q   <= '0;
			first_col_q <= 1'b1;
			run_min_q   <= '0;
			sat_seen_q  <= 1'b0;
		end else if (acc) begin
			run_min_q <= run_min_d;
			if (is_end) begin
				row_pos_q   <= '0;
				first_col_q <= 1'b1;
				sat_seen_q  <= 1'b0;
			end else begin
				sat_seen_q <= sat_d;
				if (col_done) begin
					row_pos_q   <= '0;
					first_col_q <= 1'b0;
				end else begin
					row_pos_q <= ROW_W'(row_nxt);
				end
			end
		end
	end

	// window realign after a row_count write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_RUN;
			cnt_q <= '0;
		end else if (cfg_wr) begin
			seq_q <= SEQ_LOAD;
		end else begin
			case (seq_q)
				SEQ_LOAD: begin
					cnt_q <= '0;
					seq_q <= SEQ_SHIFT;
				end
				SEQ_SHIFT: begin
					if (realign_go) begin
						cnt_q <= cnt_q + ROW_W'(1);
					end else begin
						seq_q <= SEQ_RUN;
					end
				end
				default: begin
					seq_q <= SEQ_RUN;
				end
			endcase
		end
	end

	// head tap of the window, prev of the row above the current one
	always_ff @(posedge clk) begin
		if (ctl.shift && !ctl.load) begin
			w0_q <= win_w[1];
		end
	end

	assign win_w[0]          = w0_q;
	assign win_w[MAX_ROWS+1] = '0;

	for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
		msp_cell u_cell (
			.clk     (clk),
			.idx     (ROW_W'(i)),
			.ctl     (ctl),
			.win_in  (win_w[i+2]),
			.win_out (win_w[i+1])
		);
	end

	// output register, refilled in the cycle the old beat drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && is_end) begin
			out_valid_q <= 1'b1;
		end else if (path_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && is_end) begin
			out_min_q <= run_min_d;
			out_sat_q <= sat_d;
		end
	end

	assign path_out.valid     = out_valid_q;
	assign path_out.path_min  = out_min_q;
	assign path_out.saturated = out_sat_q;

	// a row_count write always blocks cell_in for the realign
	a_cfg_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !cell_in.ready)
		else $error("cell_in ready right after a row_count write");

	// a matrix end beat always lands in the output register
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_end) |=> path_out.valid)
		else $error("matrix end beat produced no result");

	// after a matrix end the next matrix starts at row 0, first column
	a_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_end) |=> (row_pos_q == '0) && first_col_q && !sat_seen_q)
		else $error("matrix state not restarted after matrix end");

endmodule

>>> hdl/msp_cell.sv
// one row cell: previous and current column cost plus one tap of the read window
// depends on msp_pkg
module msp_cell (
	input  logic                    clk,
	input  logic [msp_pkg::ROW_W-1:0] idx,
	input  msp_pkg::msp_ctl_t       ctl,
	input  msp_pkg::cost_t          win_in,
	output msp_pkg::cost_t          win_out
);
	import msp_pkg::*;

	cost_t prev_q;
	cost_t cur_q;
	cost_t win_q;
	cost_t cur_d;
	cost_t prev_d;

	always_comb begin
		cur_d  = (ctl.wr && (ctl.row == idx)) ? ctl.cost : cur_q;
		prev_d = ctl.col_end ? cur_d : prev_q;
	end

	// window tap holds prev of (head row + own index)
	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		prev_q <= prev_d;
		if (ctl.load) begin
			win_q <= prev_d;
		end else if (ctl.shift) begin
			win_q <= win_in;
		end
	end

	assign win_out = win_q;

endmodule

>>> tb/sv/min_path_sum_column_dp_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for min_path_sum_column_dp: cell stream in, path minimum out
// depends on msp_pkg, msp_ifs and the block itself
module min_path_sum_column_dp_tb;
	import msp_pkg::*;

	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 8;
	localparam int MAX_REPORTS   = 100;

	localparam logic [PADDR_W-1:0] ADDR_ROW_COUNT = {REG_ROW_COUNT, 2'b00};
	localparam cell_t   CELL_MAX = 16'sh7fff;
	localparam cell_t   CELL_MIN = 16'sh8000;
	localparam longint  COST_HI  = 64'sd2147483647;
	localparam longint  COST_LO  = -64'sd2147483648;
	localparam cost_t   COST_TOP = 32'sh7fffffff;
	localparam cost_t   COST_BOT = 32'sh80000000;

	typedef struct packed {
		cost_t path_min;
		logic  saturated;
	} path_result_t;

	// mirror of the column dp plus the queue of results still owed by the block
	class min_path_board;
		cost_t                prev_cost [MAX_ROWS];
		cost_t                cur_cost [MAX_ROWS];
		bit [MAX_ROWS-1:0]    prev_wr;
		bit [MAX_ROWS-1:0]    cur_wr;
		int unsigned          row_pos;
		bit                   first_col;
		cost_t                col_min;
		bit                   sat_flag;
		logic [RCNT_W-1:0]    rows_reg;
		path_result_t         pending_results[$];
		int                   errors;

		function new();
			for (int i = 0; i < MAX_ROWS; i++) begin
				prev_cost[i] = '0;
				cur_cost[i]  = '0;
			end
			prev_wr   = '0;
			cur_wr    = '0;
			row_pos   = 0;
			first_col = 1'b1;
			col_min   = '0;
			sat_flag  = 1'b0;
			rows_reg  = RCNT_W'(1);
			errors    = 0;
		endfunction

		function int unsigned used_rows(logic [RCNT_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > MAX_ROWS)
				return MAX_ROWS;
			return 32'(v);
		endfunction

		// rows of the previous column that hold a stored cost, counted from row 0
		function int unsigned written_rows();
			int unsigned n;
			n = 0;
			while (n < MAX_ROWS && prev_wr[n])
				n++;
			return n;
		endfunction

		function cost_t clamp_sum(cost_t a, cost_t b);
			longint s;
			s = longint'(a) + longint'(b);
			if (s > COST_HI) begin
				sat_flag = 1'b1;
				return COST_TOP;
			end
			if (s < COST_LO) begin
				sat_flag = 1'b1;
				return COST_BOT;
			end
			return cost_t'(s);
		endfunction

		// one accepted cell beat: cost of the cell, column bookkeeping, result on matrix end
		function void fold_cell(cell_t cell_v, logic last);
			int unsigned  rows;
			int unsigned  row;
			cost_t        best;
			cost_t        cost;
			path_result_t res;
			rows = used_rows(rows_reg);
			row  = (row_pos >= rows) ? rows - 1 : row_pos;
			if (first_col) begin
				cost = cost_t'(cell_v);
			end else begin
				best = prev_cost[row];
				if (row > 0 && prev_cost[row-1] < best)
					best = prev_cost[row-1];
				if (row + 1 < rows && prev_cost[row+1] < best)
					best = prev_cost[row+1];
				cost = clamp_sum(cost_t'(cell_v), best);
			end
			cur_cost[row] = cost;
			cur_wr[row]   = 1'b1;
			if (row == 0 || cost < col_min)
				col_min = cost;
			if (row + 1 >= rows) begin
				prev_cost = cur_cost;
				prev_wr   = cur_wr;
				first_col = 1'b0;
				row_pos   = 0;
			end else begin
				row_pos = row + 1;
			end
			if (last) begin
				res.path_min  = col_min;
				res.saturated = sat_flag;
				pending_results.push_back(res);
				row_pos   = 0;
				first_col = 1'b1;
				sat_flag  = 1'b0;
			end
		endfunction

		task report(string msg);
			errors++;
			// keep the log short if the block is badly off
			if (errors <= MAX_REPORTS)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_result(cost_t got_min, logic got_sat);
			path_result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result beat with nothing owed: path_min %0d saturated %0b",
					got_min, got_sat));
				return;
			end
			want = pending_results.pop_front();
			if (got_min !== want.path_min)
				report($sformatf("path_min %0d, want %0d", got_min, want.path_min));
			if (got_sat !== want.saturated)
				report($sformatf("saturated %0b, want %0b", got_sat, want.saturated));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	msp_in_if  cell_in ();
	msp_out_if path_out ();

	min_path_board board;
	int            send_idle;
	int            recv_idle;
	int            cells_sent;
	int            cycles;

	min_path_sum_column_dp u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cell_in  (cell_in),
		.path_out (path_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// both channels sampled at the rising edge; the input beat is folded in first
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (cell_in.valid === 1'b1 && cell_in.ready === 1'b1)
				board.fold_cell(cell_in.cell_value, cell_in.matrix_end);
			if (path_out.valid === 1'b1 && path_out.ready === 1'b1)
				board.check_result(path_out.path_min, path_out.saturated);
		end
	end

	// receiver back-pressure, redrawn every cycle
	initial begin
		path_out.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			path_out.ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("min_path_sum_column_dp_tb: done, errors");
		$finish;
	end

	function automatic cell_t any_cell();
		case ($urandom_range(0, 9))
			0: return CELL_MAX;
			1: return CELL_MIN;
			// small values keep neighbor costs close, so the min choice matters
			2, 3: return cell_t'(int'($urandom_range(0, 40)) - 20);
			default: return cell_t'($urandom);
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_cell(cell_t v, logic last);
		while ($urandom_range(0, 99) < send_idle) begin
			cell_in.valid <= 1'b0;
			@(negedge clk);
		end
		cell_in.valid      <= 1'b1;
		cell_in.cell_value <= v;
		cell_in.matrix_end <= last;
		do @(posedge clk); while (cell_in.ready !== 1'b1);
		cells_sent++;
		@(negedge clk);
	endtask

	task automatic send_matrix(int unsigned count, bit close);
		for (int unsigned i = 0; i < count; i++)
			send_cell(any_cell(), close && i == count - 1);
	endtask

	// row_count write and read-back, only once the block has gone quiet
	task automatic write_rows(logic [RCNT_W-1:0] v);
		cell_in.valid <= 1'b0;
		while (board.pending_results.size() != 0)
			@(negedge clk);
		// a plain cell beat owes no result, so give the block its latency to finish it
		repeat (SETTLE_CYCLES) @(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_ROW_COUNT;
		pwdata  <= PDATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		board.rows_reg = v;
		@(negedge clk);
		// read setup, psel stays high
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== PDATA_W'(v))
			board.report($sformatf("row_count reads %0d, wrote %0d", prdata, v));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [RCNT_W-1:0] pick_rows();
		logic [RCNT_W-1:0] v;
		case ($urandom_range(0, 31))
			0: v = '0;
			1: v = RCNT_W'(MAX_ROWS);
			2: v = RCNT_W'($urandom_range(MAX_ROWS + 1, (1 << RCNT_W) - 1));
			3: v = RCNT_W'($urandom_range(9, MAX_ROWS));
			default: v = RCNT_W'($urandom_range(1, 8));
		endcase
		// mid-matrix growth must stay inside the part of the previous column that was stored
		if (!board.first_col && board.used_rows(v) > board.written_rows())
			v = RCNT_W'(board.written_rows());
		return v;
	endfunction

	// segments of whole matrices; some end inside a column, some are left open
	// so that the next row_count write lands in the middle of a matrix
	task automatic run_phase(int budget);
		int          stop_at;
		int unsigned rows;
		int unsigned cols;
		int unsigned count;
		stop_at = cells_sent + budget;
		while (cells_sent < stop_at) begin
			write_rows(pick_rows());
			repeat ($urandom_range(1, 4)) begin
				rows  = board.used_rows(board.rows_reg);
				cols  = (rows > 8) ? $urandom_range(1, 2) : $urandom_range(1, 6);
				count = rows * cols;
				if ($urandom_range(0, 4) == 0)
					count = $urandom_range(1, count);
				send_matrix(count, 1'b1);
			end
			if ($urandom_range(0, 3) == 0) begin
				rows = board.used_rows(board.rows_reg);
				send_matrix($urandom_range(1, 2 * rows), 1'b0);
			end
		end
	endtask

	initial begin
		board              = new();
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		cell_in.valid      = 1'b0;
		cell_in.cell_value = '0;
		cell_in.matrix_end = 1'b0;
		cells_sent         = 0;
		send_idle          = 12;
		recv_idle          = 70;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// one row: the result is the plain row sum
		write_rows(RCNT_W'(1));
		send_cell(CELL_MAX, 1'b0);
		send_cell(CELL_MIN, 1'b0);
		send_cell(16'sd1, 1'b1);
		// matrix of a single beat
		send_cell(CELL_MIN, 1'b1);

		// row count zero acts as one row
		write_rows(RCNT_W'(0));
		send_cell(16'sd5, 1'b0);
		send_cell(-16'sd3, 1'b0);
		send_cell(16'sd7, 1'b1);

		// full 3x3 grid, edge rows see two neighbors, middle row three
		write_rows(RCNT_W'(3));
		send_cell(CELL_MAX, 1'b0);
		send_cell(CELL_MIN, 1'b0);
		send_cell(16'sd0, 1'b0);
		send_cell(-16'sd1, 1'b0);
		send_cell(16'sd100, 1'b0);
		send_cell(CELL_MIN, 1'b0);
		send_cell(16'sd7, 1'b0);
		send_cell(CELL_MAX, 1'b0);
		send_cell(-16'sd50, 1'b1);

		// matrix end inside a column: min over the rows seen so far
		send_cell(16'sd3, 1'b0);
		send_cell(CELL_MIN, 1'b0);
		send_cell(16'sd2, 1'b0);
		send_cell(-16'sd9, 1'b1);

		// row count above the maximum acts as the maximum
		write_rows(RCNT_W'((1 << RCNT_W) - 1));
		send_cell(CELL_MAX, 1'b0);
		send_cell(16'sd0, 1'b0);
		send_cell(CELL_MIN, 1'b1);

		// random part: sender idles lightly, receiver heavily
		run_phase(330);

		send_idle = 70;
		recv_idle = 12;
		run_phase(330);

		// no idling from here on
		send_idle = 0;
		recv_idle = 0;
		run_phase(340);

		cell_in.valid <= 1'b0;
		while (board.pending_results.size() != 0)
			@(negedge clk);
		// catch any stray result beat after the last one owed
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (board.errors == 0)
			$display("min_path_sum_column_dp_tb: done, clean");
		else
			$display("min_path_sum_column_dp_tb: done, errors");
		$finish;
	end

endmodule
